>>> src/sobel_edge_magnitude_core_defines.svh
// Assertion macros shared by the Sobel edge magnitude RTL.
// Empty bodies when SYNTHESIS is defined; expects clk and rst_n in scope.
`ifndef SOBEL_EDGE_MAGNITUDE_CORE_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SEM_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("sobel core: invariant violated");
`define SEM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sobel core: implication violated");
`define SEM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sobel core: next-cycle implication violated");
`else
`define SEM_ASSERT(label, cond)
`define SEM_ASSERT_NOW(label, ante, cons)
`define SEM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> src/sem_pkg.sv
// Package for the Sobel edge magnitude core: payload structs, FSM states,
// register indexes and arithmetic constants. No dependencies.
package sem_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0]  edge_magnitude;
    logic [9:0]  out_col;
    logic [11:0] out_row;
    logic        last_of_run;
    logic        last_of_image;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_GRAD,
    ST_SQ,
    ST_SQRT,
    ST_OUT
  } state_t;

  // configuration register indexes
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_COLOR_MODE   = 2'd2;

  localparam logic [10:0] WIDTH_RESET  = 11'd1024;
  localparam logic [12:0] HEIGHT_RESET = 13'd1024;

  // divide by 3 for sums up to 765: (s * 683) >> 11 is exact
  localparam logic [9:0] DIV3_RECIP = 10'd683;
  localparam int         DIV3_SHIFT = 11;

  // row / column choice of the current result
  localparam logic KIND_PREV = 1'b0;  // row y-1 or column x-1
  localparam logic KIND_LAST = 1'b1;  // last row or last column

  function automatic logic [7:0] mux3(input logic [7:0] v0, input logic [7:0] v1,
                                      input logic [7:0] v2, input logic [1:0] sel);
    logic [7:0] r;
    unique case (sel)
      2'd0:    r = v0;
      2'd1:    r = v1;
      default: r = v2;
    endcase
    return r;
  endfunction

  function automatic logic [10:0] tap_sum(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c);
    return {3'b000, a} + {2'b00, b, 1'b0} + {3'b000, c};
  endfunction

endpackage

>>> src/sem_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

>>> src/sobel_edge_magnitude_core.sv
// Streaming 3x3 Sobel edge magnitude over a raster image. One pixel request
// at a time: the IDLE and READ states take the pixel and update the line
// buffers and the window, then each result passes through the gradient,
// squares, 8 square-root steps and output, plus any output stall; 0 to 4
// results per pixel. The 8-step bit-serial square root dominates. Depends
// on sem_pkg, sem_ram and sobel_edge_magnitude_core_defines.svh.
`include "sobel_edge_magnitude_core_defines.svh"
module sobel_edge_magnitude_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  sem_pkg::pixel_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output sem_pkg::result_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [12:0]      cfg_wdata
);
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int DIV3_TOP = sem_pkg::DIV3_SHIFT + 7;

  sem_pkg::state_t state_r, state_nxt;

  // configuration
  logic [10:0] cfg_width_r;
  logic [12:0] cfg_height_r;
  logic        cfg_rgb_r;
  logic        cfg_we;

  logic [XW:0] w_eff;
  logic [YW:0] h_eff;

  // raster position of the next pixel
  logic [XW-1:0] x_r;
  logic [YW-1:0] y_r;
  logic [XW:0]   x_p1;
  logic [YW:0]   y_p1;

  // pixel being processed
  logic [7:0]  gray_r;
  logic [9:0]  rgb_sum;
  logic [19:0] gray_prod;

  logic [7:0] win_r [3][3];

  // line buffers
  logic       lb_re, lb_we;
  logic [7:0] prev_rdata, prev2_rdata;

  // result iteration
  logic [XW-1:0] cur_x_r;
  logic [YW-1:0] cur_y_r;
  logic row_b_r, col_a_r, col_b_r;
  logic rk_r, ck_r;
  logic row_a, row_b, col_a, col_b, go;
  logic last_run;

  // arithmetic
  logic [1:0]  rsel [3];
  logic [1:0]  csel [3];
  logic [7:0]  rowpick [3][3];
  logic [7:0]  e [3][3];
  logic signed [11:0] sx_r, sy_r, sx_nxt, sy_nxt;
  logic signed [23:0] sqx, sqy;
  logic [20:0] s_r;
  logic [7:0]  m_r, cand;
  logic [2:0]  step_r;
  logic [15:0] cand_sq;
  logic [16:0] thr;

  logic [XW-1:0] oc;
  logic [YW-1:0] orow;

  // effective geometry: zero reads as one, above the maximum saturates
  always_comb begin
    if (cfg_width_r == '0) begin
      w_eff = (XW+1)'(1);
    end else if (32'(cfg_width_r) > MAX_WIDTH) begin
      w_eff = (XW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (XW+1)'(cfg_width_r);
    end
    if (cfg_height_r == '0) begin
      h_eff = (YW+1)'(1);
    end else if (32'(cfg_height_r) > MAX_HEIGHT) begin
      h_eff = (YW+1)'(MAX_HEIGHT);
    end else begin
      h_eff = (YW+1)'(cfg_height_r);
    end
  end

  assign x_p1 = {1'b0, x_r} + (XW+1)'(1);
  assign y_p1 = {1'b0, y_r} + (YW+1)'(1);

  // which output rows / columns this pixel completes
  assign row_a = (y_r != '0);
  assign row_b = (y_p1 == h_eff);
  assign col_a = (x_r != '0);
  assign col_b = (x_p1 == w_eff);
  assign go    = (row_a | row_b) & (col_a | col_b);

  // last result of this request: no column or row left to visit
  assign last_run = !(ck_r == sem_pkg::KIND_PREV && col_b_r) &&
                    !(rk_r == sem_pkg::KIND_PREV && row_b_r);

  // gray conversion
  assign rgb_sum   = {2'b00, in_data.red} + {2'b00, in_data.green} + {2'b00, in_data.blue};
  assign gray_prod = rgb_sum * sem_pkg::DIV3_RECIP;

  assign cfg_we = cfg_valid && cfg_ready;

  // ---------------- FSM ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sem_pkg::ST_IDLE: if (in_valid) state_nxt = sem_pkg::ST_READ;
      sem_pkg::ST_READ: state_nxt = go ? sem_pkg::ST_GRAD : sem_pkg::ST_IDLE;
      sem_pkg::ST_GRAD: state_nxt = sem_pkg::ST_SQ;
      sem_pkg::ST_SQ:   state_nxt = sem_pkg::ST_SQRT;
      sem_pkg::ST_SQRT: if (step_r == '0) state_nxt = sem_pkg::ST_OUT;
      sem_pkg::ST_OUT: begin
        if (out_ready) begin
          state_nxt = last_run ? sem_pkg::ST_IDLE : sem_pkg::ST_GRAD;
        end
      end
      default: state_nxt = sem_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == sem_pkg::ST_IDLE);
    out_valid = (state_r == sem_pkg::ST_OUT);
    lb_re     = (state_r == sem_pkg::ST_IDLE) && in_valid;
    lb_we     = (state_r == sem_pkg::ST_READ);
    cfg_ready = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sem_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------- config and position ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= sem_pkg::WIDTH_RESET;
      cfg_height_r <= sem_pkg::HEIGHT_RESET;
      cfg_rgb_r    <= 1'b1;
      x_r          <= '0;
      y_r          <= '0;
    end else if (cfg_we) begin
      // a write to a defined register restarts the frame
      unique case (cfg_index)
        sem_pkg::CFG_IMAGE_WIDTH: begin
          cfg_width_r <= cfg_wdata[10:0];
          x_r         <= '0;
          y_r         <= '0;
        end
        sem_pkg::CFG_IMAGE_HEIGHT: begin
          cfg_height_r <= cfg_wdata;
          x_r          <= '0;
          y_r          <= '0;
        end
        sem_pkg::CFG_COLOR_MODE: begin
          cfg_rgb_r <= cfg_wdata[0];
          x_r       <= '0;
          y_r       <= '0;
        end
        default: ;
      endcase
    end else if (state_r == sem_pkg::ST_READ) begin
      if (col_b || x_p1 > w_eff) begin
        x_r <= '0;
        y_r <= (y_p1 >= h_eff) ? '0 : y_p1[YW-1:0];
      end else begin
        x_r <= x_p1[XW-1:0];
      end
    end
  end

  // ---------------- line buffers ----------------
  sem_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_lb_prev (
    .clk   (clk),
    .we    (lb_we),
    .waddr (x_r),
    .wdata (gray_r),
    .re    (lb_re),
    .raddr (x_r),
    .rdata (prev_rdata)
  );

  sem_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_lb_prev2 (
    .clk   (clk),
    .we    (lb_we),
    .waddr (x_r),
    .wdata (prev_rdata),
    .re    (lb_re),
    .raddr (x_r),
    .rdata (prev2_rdata)
  );

  // ---------------- window ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[k][c] <= '0;
        end
      end
    end else if (state_r == sem_pkg::ST_READ) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= win_r[k][1];
        win_r[k][1] <= win_r[k][2];
      end
      win_r[0][2] <= prev2_rdata;
      win_r[1][2] <= prev_rdata;
      win_r[2][2] <= gray_r;
    end
  end

  // clamp indexes for replicated borders
  always_comb begin
    if (rk_r == sem_pkg::KIND_PREV) begin
      rsel[0] = (cur_y_r == YW'(1)) ? 2'd1 : 2'd0;
      rsel[1] = 2'd1;
    end else begin
      rsel[0] = (cur_y_r == '0) ? 2'd2 : 2'd1;
      rsel[1] = 2'd2;
    end
    rsel[2] = 2'd2;
    if (ck_r == sem_pkg::KIND_PREV) begin
      csel[0] = (cur_x_r == XW'(1)) ? 2'd1 : 2'd0;
      csel[1] = 2'd1;
    end else begin
      csel[0] = (cur_x_r == '0) ? 2'd2 : 2'd1;
      csel[1] = 2'd2;
    end
    csel[2] = 2'd2;
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < 3; c++) begin
        rowpick[k][c] = sem_pkg::mux3(win_r[k][0], win_r[k][1], win_r[k][2], csel[c]);
      end
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        e[r][c] = sem_pkg::mux3(rowpick[0][c], rowpick[1][c], rowpick[2][c], rsel[r]);
      end
    end
    sx_nxt = $signed({1'b0, sem_pkg::tap_sum(e[0][2], e[1][2], e[2][2])}) -
             $signed({1'b0, sem_pkg::tap_sum(e[0][0], e[1][0], e[2][0])});
    sy_nxt = $signed({1'b0, sem_pkg::tap_sum(e[2][0], e[2][1], e[2][2])}) -
             $signed({1'b0, sem_pkg::tap_sum(e[0][0], e[0][1], e[0][2])});
  end

  assign sqx = sx_r * sx_r;
  assign sqy = sy_r * sy_r;

  // square root step: accept bit if s > cand^2 - cand
  assign cand    = m_r | (8'd1 << step_r);
  assign cand_sq = {8'b0, cand} * {8'b0, cand};
  assign thr     = {1'b0, cand_sq} - {9'b0, cand};

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rk_r <= sem_pkg::KIND_PREV;
      ck_r <= sem_pkg::KIND_PREV;
    end else begin
      unique case (state_r)
        sem_pkg::ST_IDLE: begin
          gray_r <= cfg_rgb_r ? gray_prod[DIV3_TOP-:8] : in_data.red;
        end
        sem_pkg::ST_READ: begin
          cur_x_r <= x_r;
          cur_y_r <= y_r;
          row_b_r <= row_b;
          col_a_r <= col_a;
          col_b_r <= col_b;
          rk_r    <= row_a ? sem_pkg::KIND_PREV : sem_pkg::KIND_LAST;
          ck_r    <= col_a ? sem_pkg::KIND_PREV : sem_pkg::KIND_LAST;
        end
        sem_pkg::ST_GRAD: begin
          sx_r <= sx_nxt;
          sy_r <= sy_nxt;
        end
        sem_pkg::ST_SQ: begin
          s_r    <= 21'($unsigned(sqx) + $unsigned(sqy));
          m_r    <= '0;
          step_r <= 3'd7;
        end
        sem_pkg::ST_SQRT: begin
          if (21'(thr) < s_r) begin
            m_r <= cand;
          end
          step_r <= step_r - 3'd1;
        end
        sem_pkg::ST_OUT: begin
          if (out_ready) begin
            if (ck_r == sem_pkg::KIND_PREV && col_b_r) begin
              ck_r <= sem_pkg::KIND_LAST;
            end else if (rk_r == sem_pkg::KIND_PREV && row_b_r) begin
              rk_r <= sem_pkg::KIND_LAST;
              ck_r <= col_a_r ? sem_pkg::KIND_PREV : sem_pkg::KIND_LAST;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- result ----------------
  assign oc   = (ck_r == sem_pkg::KIND_PREV) ? cur_x_r - XW'(1) : cur_x_r;
  assign orow = (rk_r == sem_pkg::KIND_PREV) ? cur_y_r - YW'(1) : cur_y_r;

  always_comb begin
    out_data.edge_magnitude = m_r;
    out_data.out_col        = 10'(oc);
    out_data.out_row        = 12'(orow);
    out_data.last_of_run    = last_run;
    out_data.last_of_image  = ({1'b0, oc} == w_eff - (XW+1)'(1)) &&
                              ({1'b0, orow} == h_eff - (YW+1)'(1));
  end

  // ---------------- checks ----------------
  `SEM_ASSERT(a_col_in_frame, ({1'b0, x_r} < w_eff))
  `SEM_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready && !out_valid)
  `SEM_ASSERT_NOW(a_out_excl_in, out_valid, !in_ready && !lb_we)
endmodule

>>> sim/sobel_edge_magnitude_core_test.sv
// Self-checking testbench for sobel_edge_magnitude_core: streams pixel
// frames over several geometries and color modes and checks every result.
// Depends on sem_pkg and the core RTL only.
module sobel_edge_magnitude_core_test;

  localparam int LB_DEPTH    = 1024;
  localparam int MAX_ROWS    = 4096;
  localparam int SETTLE_WAIT = 60;    // cycles; covers a pixel that causes no result
  localparam int STALL_LIMIT = 3000;  // cycles without any request accepted

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  sem_pkg::pixel_t   in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  sem_pkg::result_t  out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = sem_pkg::CFG_IMAGE_WIDTH;
  logic [12:0]       cfg_wdata = '0;

  sobel_edge_magnitude_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial forever #10 clk = ~clk;

  // ---------------------------------------------------------------------
  // Golden Sobel pipeline state, mirrored from the block's behavior
  // ---------------------------------------------------------------------
  logic [10:0] width_reg  = sem_pkg::WIDTH_RESET;
  logic [12:0] height_reg = sem_pkg::HEIGHT_RESET;
  logic        rgb_mode   = 1'b1;
  logic [7:0]  row_above [LB_DEPTH];  // row y-1
  logic [7:0]  row_above2[LB_DEPTH];  // row y-2
  logic [7:0]  win[3][3];             // [row y-2,y-1,y][col x-2,x-1,x]
  int          pix_col, pix_row;

  sem_pkg::pixel_t  pixel_queue[$];     // pixels waiting for the driver
  sem_pkg::result_t expected_edges[$];  // predicted results, oldest first

  int  pixels_sent, edges_seen, mismatches, phases_run;
  bit  hold_pixels, calm;
  int  quiet_cycles;

  function automatic int eff_w();
    if (width_reg == 0) return 1;
    if (width_reg > LB_DEPTH) return LB_DEPTH;
    return int'(width_reg);
  endfunction

  function automatic int eff_h();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_ROWS) return MAX_ROWS;
    return int'(height_reg);
  endfunction

  // round(sqrt(sx^2+sy^2)), half up, saturated at 255
  function automatic logic [7:0] window_magnitude(int t, int m, int b, int l, int c, int r);
    int sx, sy, s, k;
    sx = (win[t][r] + 2 * win[m][r] + win[b][r]) - (win[t][l] + 2 * win[m][l] + win[b][l]);
    sy = (win[b][l] + 2 * win[b][c] + win[b][r]) - (win[t][l] + 2 * win[t][c] + win[t][r]);
    s = sx * sx + sy * sy;
    k = 0;
    while (k < 255 && s > k * k + k) k++;
    return 8'(k);
  endfunction

  // Shift one pixel in and queue the results it releases.
  task automatic predict_edges(input sem_pkg::pixel_t p);
    int w, h, x, y, nr, nc;
    int rs[2][4], cs[2][4];
    logic [7:0] gray;
    sem_pkg::result_t e;
    w = eff_w(); h = eff_h(); x = pix_col; y = pix_row;
    gray = rgb_mode ? 8'((int'(p.red) + int'(p.green) + int'(p.blue)) / 3) : p.red;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = row_above2[x];
    win[1][2] = row_above[x];
    win[2][2] = gray;
    row_above2[x] = row_above[x];
    row_above[x] = gray;
    nr = 0; nc = 0;
    // top/bottom edges replicate by reusing window rows; same for columns
    if (y >= 1) begin
      rs[nr] = '{y - 1, (y == 1) ? 1 : 0, 1, 2}; nr++;
    end
    if (y == h - 1) begin
      rs[nr] = '{y, (y == 0) ? 2 : 1, 2, 2}; nr++;
    end
    if (x >= 1) begin
      cs[nc] = '{x - 1, (x == 1) ? 1 : 0, 1, 2}; nc++;
    end
    if (x == w - 1) begin
      cs[nc] = '{x, (x == 0) ? 2 : 1, 2, 2}; nc++;
    end
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        e.edge_magnitude = window_magnitude(rs[i][1], rs[i][2], rs[i][3],
                                            cs[j][1], cs[j][2], cs[j][3]);
        e.out_col       = 10'(cs[j][0]);
        e.out_row       = 12'(rs[i][0]);
        e.last_of_run   = (i == nr - 1) && (j == nc - 1);
        e.last_of_image = (cs[j][0] == w - 1) && (rs[i][0] == h - 1);
        expected_edges.push_back(e);
      end
    end
    if (x + 1 >= w) begin
      pix_col = 0;
      pix_row = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      pix_col = x + 1;
    end
  endtask

  // ---------------------------------------------------------------------
  // Pixel driver: pops pixel_queue, idles in random bursts
  // ---------------------------------------------------------------------
  int in_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_edges(in_data);
        pixels_sent++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pixel_queue.size() > 0 && !hold_pixels) begin
          if (!calm && $urandom_range(0, 5) == 0) begin
            in_gap = $urandom_range(0, 10);  // start a burst of idle cycles
            in_valid <= 1'b0;
          end else begin
            in_data <= pixel_queue.pop_front();
            in_valid <= 1'b1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result monitor: random back-pressure, in-order compare
  // ---------------------------------------------------------------------
  int out_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        edges_seen++;
        if (expected_edges.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result %p", out_data);
        end else begin
          sem_pkg::result_t e;
          e = expected_edges.pop_front();
          if (out_data.edge_magnitude !== e.edge_magnitude ||
              out_data.out_col !== e.out_col || out_data.out_row !== e.out_row ||
              out_data.last_of_run !== e.last_of_run ||
              out_data.last_of_image !== e.last_of_image) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: result mismatch: expected %p, got %p", e, out_data);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        out_gap = $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: any accepted request resets the count
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
      $display("** sobel_edge_magnitude_core: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus sequencing
  // ---------------------------------------------------------------------
  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      sem_pkg::CFG_IMAGE_WIDTH:  width_reg = val[10:0];
      sem_pkg::CFG_IMAGE_HEIGHT: height_reg = val;
      sem_pkg::CFG_COLOR_MODE:   rgb_mode = val[0];
      default: ;
    endcase
    pix_col = 0;  // a write to a defined register restarts the frame
    pix_row = 0;
  endtask

  task automatic set_geometry(input int w, input int h, input bit rgb);
    write_reg(sem_pkg::CFG_IMAGE_WIDTH, 13'(w));
    write_reg(sem_pkg::CFG_IMAGE_HEIGHT, 13'(h));
    write_reg(sem_pkg::CFG_COLOR_MODE, 13'(rgb));
    phases_run++;
  endtask

  // Block is idle once nothing is queued, in flight or predicted.
  task automatic drain();
    hold_pixels = 1'b0;
    while (pixel_queue.size() > 0 || in_valid || expected_edges.size() > 0)
      @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  function automatic sem_pkg::pixel_t random_pixel();
    sem_pkg::pixel_t p;
    if ($urandom_range(0, 3) == 0)
      p = {{8{$urandom_range(0, 1) == 1}}, {8{$urandom_range(0, 1) == 1}},
           {8{$urandom_range(0, 1) == 1}}};
    else
      p = sem_pkg::pixel_t'(24'($urandom));
    return p;
  endfunction

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) pixel_queue.push_back(random_pixel());
  endtask

  initial begin
    int w, h, n;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (int k = 0; k < 3; k++)
      for (int j = 0; j < 3; j++) win[k][j] = '0;
    for (int i = 0; i < LB_DEPTH; i++) begin
      row_above[i]  = '0;
      row_above2[i] = '0;
    end
    pix_col = 0; pix_row = 0;

    // Directed: 3x3 gray checkerboard of extremes plus wrap into next frame
    set_geometry(3, 3, 1'b0);
    for (int i = 0; i < 11; i++)
      pixel_queue.push_back({((i % 2) ? 8'hFF : 8'h00), 8'h5A, 8'hA5});
    drain();
    // zero width and height read as 1x1; RGB extremes and truncating divide
    set_geometry(0, 0, 1'b1);
    pixel_queue.push_back({8'hFF, 8'hFF, 8'hFF});
    pixel_queue.push_back({8'h00, 8'h00, 8'h00});
    pixel_queue.push_back({8'hFF, 8'h00, 8'h01});
    drain();
    // single column, tall strip
    set_geometry(1, 4, 1'b1);
    pixel_queue.push_back({8'hFF, 8'hFF, 8'hFF});
    pixel_queue.push_back({8'h00, 8'h00, 8'h00});
    pixel_queue.push_back({8'hFF, 8'hFF, 8'hFE});
    pixel_queue.push_back({8'h01, 8'h00, 8'h00});
    drain();
    // single row
    set_geometry(4, 1, 1'b0);
    for (int i = 0; i < 4; i++) pixel_queue.push_back({8'(255 * (i / 2)), 8'h00, 8'h00});
    drain();

    // Oversized registers saturate: a wide single row, then a tall strip
    set_geometry(2047, 1, 1'b0);
    push_random(20);
    drain();
    set_geometry(3, 8191, 1'b1);
    push_random(18);
    drain();

    // Random geometries, small frames
    for (int ph = 0; ph < 14; ph++) begin
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 6);
      if (ph == 13) calm = 1'b1;  // final stretch without idling
      set_geometry(w, h, $urandom_range(0, 1));
      n = $urandom_range(w * h, w * h + w + 2);
      push_random(n);
      if (ph == 5) begin
        // hold the sender until every pending result has come back
        hold_pixels = 1'b0;
        while (pixel_queue.size() > n / 2) @(posedge clk);
        hold_pixels = 1'b1;
        repeat (2) @(posedge clk);
        while (expected_edges.size() > 0 || in_valid) @(posedge clk);
      end
      drain();
    end

    $display("Covered %0d pixels, %0d results, over %0d geometry/mode settings.",
             pixels_sent, edges_seen, phases_run);
    if (mismatches == 0 && expected_edges.size() == 0) begin
      $display("** sobel_edge_magnitude_core: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results never seen", mismatches, expected_edges.size());
      $display("** sobel_edge_magnitude_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/sem_pkg.sv
src/sem_ram.sv
src/sobel_edge_magnitude_core.sv
sim/sobel_edge_magnitude_core_test.sv
